// File: design/fplog_pkg.sv
// Shared constants for the fixed-point natural logarithm core.
// Holds the data widths, the Q16 constants and the log2 correction table.
// No dependencies; every other file of the core refers to it by scoped name.
`default_nettype none

package fplog_pkg;

  // Field and internal widths.
  localparam int unsigned ValueW  = 32;
  localparam int unsigned IpW     = 5;
  localparam int unsigned FracW   = 16;
  localparam int unsigned SegW    = 7;
  localparam int unsigned PosW    = FracW - SegW;
  localparam int unsigned CorrW   = 13;
  localparam int unsigned L2W     = 22;
  localparam int unsigned ScaleW  = 11;
  localparam int unsigned ResultW = 16;

  // Q16 constants.
  localparam logic [15:0] Ln2Q16    = 16'd45426;
  localparam logic [15:0] HalfQ16   = 16'd32768;
  localparam logic [15:0] FloorBias = 16'hFFFF;
  localparam logic [ScaleW-1:0] ScaleReset = ScaleW'(64);

  // Configuration register indexes.
  localparam logic RegOutputScale = 1'b0;

  // Correction added to the raw fraction, 128 segments plus the end point.
  localparam logic [CorrW-1:0] CorrTable [129] = '{
    13'd0,    13'd224,  13'd442,  13'd654,  13'd861,  13'd1063, 13'd1259, 13'd1450,
    13'd1636, 13'd1817, 13'd1992, 13'd2163, 13'd2329, 13'd2490, 13'd2646, 13'd2797,
    13'd2944, 13'd3087, 13'd3224, 13'd3358, 13'd3487, 13'd3611, 13'd3732, 13'd3848,
    13'd3960, 13'd4068, 13'd4172, 13'd4272, 13'd4368, 13'd4460, 13'd4549, 13'd4633,
    13'd4714, 13'd4791, 13'd4864, 13'd4934, 13'd5001, 13'd5063, 13'd5123, 13'd5178,
    13'd5231, 13'd5280, 13'd5326, 13'd5368, 13'd5408, 13'd5444, 13'd5477, 13'd5507,
    13'd5533, 13'd5557, 13'd5578, 13'd5595, 13'd5610, 13'd5622, 13'd5631, 13'd5637,
    13'd5640, 13'd5641, 13'd5638, 13'd5633, 13'd5626, 13'd5615, 13'd5602, 13'd5586,
    13'd5568, 13'd5547, 13'd5524, 13'd5498, 13'd5470, 13'd5439, 13'd5406, 13'd5370,
    13'd5332, 13'd5291, 13'd5249, 13'd5203, 13'd5156, 13'd5106, 13'd5054, 13'd5000,
    13'd4944, 13'd4885, 13'd4825, 13'd4762, 13'd4697, 13'd4630, 13'd4561, 13'd4490,
    13'd4416, 13'd4341, 13'd4264, 13'd4184, 13'd4103, 13'd4020, 13'd3935, 13'd3848,
    13'd3759, 13'd3668, 13'd3575, 13'd3481, 13'd3384, 13'd3286, 13'd3186, 13'd3084,
    13'd2981, 13'd2875, 13'd2768, 13'd2659, 13'd2549, 13'd2437, 13'd2323, 13'd2207,
    13'd2090, 13'd1971, 13'd1851, 13'd1729, 13'd1605, 13'd1480, 13'd1353, 13'd1224,
    13'd1094, 13'd963,  13'd830,  13'd695,  13'd559,  13'd421,  13'd282,  13'd142,
    13'd0
  };

endpackage

`default_nettype wire

// File: design/fplog_lod_norm.sv
// Front stages of the logarithm pipeline: leading-one detection, then
// normalisation of the bits below the leading one to a 16-bit fraction.
// Depends on fplog_pkg.
`default_nettype none

module fplog_lod_norm (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            en_i,
  input  wire                            valid_i,
  input  wire [fplog_pkg::ValueW-1:0]    value_i,
  output logic                           valid_o,
  output logic [fplog_pkg::IpW-1:0]      ip_o,
  output logic [fplog_pkg::FracW-1:0]    frac_o,
  output logic                           zero_o
);

  logic                          s1_valid_q;
  logic [fplog_pkg::ValueW-1:0]  s1_value_q;
  logic [fplog_pkg::IpW-1:0]     s1_ip_q;
  logic [fplog_pkg::IpW-1:0]     s1_ip_d;
  logic                          s1_zero_q;
  logic [15:0]                   x16;
  logic [7:0]                    x8;
  logic [3:0]                    x4;
  logic [1:0]                    x2;
  logic [fplog_pkg::ValueW-1:0]  norm;
  logic                          s2_valid_q;
  logic [fplog_pkg::IpW-1:0]     s2_ip_q;
  logic [fplog_pkg::FracW-1:0]   s2_frac_q;
  logic                          s2_zero_q;

  // Leading-one position found by halving the word five times.
  always_comb begin
    s1_ip_d[4] = |value_i[31:16];
    x16        = s1_ip_d[4] ? value_i[31:16] : value_i[15:0];
    s1_ip_d[3] = |x16[15:8];
    x8         = s1_ip_d[3] ? x16[15:8] : x16[7:0];
    s1_ip_d[2] = |x8[7:4];
    x4         = s1_ip_d[2] ? x8[7:4] : x8[3:0];
    s1_ip_d[1] = |x4[3:2];
    x2         = s1_ip_d[1] ? x4[3:2] : x4[1:0];
    s1_ip_d[0] = x2[1];
  end

  // Shifting the leading one to the top puts the fraction just below it;
  // large operands lose their low bits by truncation.
  assign norm = s1_value_q << (5'd31 - s1_ip_q);

  // Valid bits of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  // Payload of both stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_value_q <= value_i;
      s1_ip_q    <= s1_ip_d;
      s1_zero_q  <= (value_i == '0);
      s2_ip_q    <= s1_ip_q;
      s2_frac_q  <= norm[30:15];
      s2_zero_q  <= s1_zero_q;
    end
  end

  assign valid_o = s2_valid_q;
  assign ip_o    = s2_ip_q;
  assign frac_o  = s2_frac_q;
  assign zero_o  = s2_zero_q;

endmodule

`default_nettype wire

// File: design/fplog_interp.sv
// Middle stages of the logarithm pipeline: correction table lookup, slope
// times position product, then the Q16 log2 sum.
// Depends on fplog_pkg for the table and the widths.
`default_nettype none

module fplog_interp (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            en_i,
  input  wire                            valid_i,
  input  wire [fplog_pkg::IpW-1:0]       ip_i,
  input  wire [fplog_pkg::FracW-1:0]     frac_i,
  input  wire                            zero_i,
  output logic                           valid_o,
  output logic [fplog_pkg::L2W-1:0]      l2_o,
  output logic                           zero_o
);

  localparam int unsigned ProdW = fplog_pkg::CorrW + fplog_pkg::PosW;

  logic [7:0]                      seg_lo;
  logic [7:0]                      seg_hi;
  logic                            s3_valid_q;
  logic [fplog_pkg::CorrW-1:0]     s3_c0_q;
  logic [fplog_pkg::CorrW-1:0]     s3_c1_q;
  logic [fplog_pkg::PosW-1:0]      s3_pos_q;
  logic [fplog_pkg::FracW-1:0]     s3_frac_q;
  logic [fplog_pkg::IpW-1:0]       s3_ip_q;
  logic                            s3_zero_q;
  logic                            neg;
  logic [fplog_pkg::CorrW-1:0]     diff;
  logic                            s4_valid_q;
  logic [ProdW-1:0]                s4_prod_q;
  logic                            s4_neg_q;
  logic [fplog_pkg::CorrW-1:0]     s4_c0_q;
  logic [fplog_pkg::FracW-1:0]     s4_frac_q;
  logic [fplog_pkg::IpW-1:0]       s4_ip_q;
  logic                            s4_zero_q;
  logic [ProdW:0]                  prod_up;
  logic [fplog_pkg::CorrW-1:0]     corr;
  logic                            s5_valid_q;
  logic [fplog_pkg::L2W-1:0]       s5_l2_q;
  logic                            s5_zero_q;

  // Segment end points from the constant table.
  assign seg_lo = {1'b0, frac_i[15:9]};
  assign seg_hi = seg_lo + 8'd1;

  // Slope magnitude and its sign.
  assign neg  = s3_c1_q < s3_c0_q;
  assign diff = neg ? (s3_c0_q - s3_c1_q) : (s3_c1_q - s3_c0_q);

  // Rising slopes round down; falling slopes round the drop up, which floors
  // the corrected value.
  always_comb begin
    prod_up = {1'b0, s4_prod_q} + (ProdW + 1)'(fplog_pkg::FloorBias);
    if (s4_neg_q) begin
      corr = s4_c0_q - fplog_pkg::CorrW'(prod_up[ProdW:16]);
    end else begin
      corr = s4_c0_q + fplog_pkg::CorrW'(s4_prod_q[ProdW-1:16]);
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else if (en_i) begin
      s3_valid_q <= valid_i;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
    end
  end

  // Payload of the three stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_c0_q   <= fplog_pkg::CorrTable[seg_lo];
      s3_c1_q   <= fplog_pkg::CorrTable[seg_hi];
      s3_pos_q  <= frac_i[fplog_pkg::PosW-1:0];
      s3_frac_q <= frac_i;
      s3_ip_q   <= ip_i;
      s3_zero_q <= zero_i;
      s4_prod_q <= diff * s3_pos_q;
      s4_neg_q  <= neg;
      s4_c0_q   <= s3_c0_q;
      s4_frac_q <= s3_frac_q;
      s4_ip_q   <= s3_ip_q;
      s4_zero_q <= s3_zero_q;
      s5_l2_q   <= {1'b0, s4_ip_q, 16'd0}
                   + fplog_pkg::L2W'(s4_frac_q)
                   + fplog_pkg::L2W'(corr);
      s5_zero_q <= s4_zero_q;
    end
  end

  assign valid_o = s5_valid_q;
  assign l2_o    = s5_l2_q;
  assign zero_o  = s5_zero_q;

endmodule

`default_nettype wire

// File: design/fplog_scale.sv
// Back stages of the logarithm pipeline: multiply by ln2, round and multiply
// by the output scale, then round and saturate into the result register.
// Depends on fplog_pkg.
`default_nettype none

module fplog_scale (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              en_i,
  input  wire                              valid_i,
  input  wire [fplog_pkg::L2W-1:0]         l2_i,
  input  wire                              zero_i,
  input  wire [fplog_pkg::ScaleW-1:0]      scale_i,
  output logic                             valid_o,
  output logic [fplog_pkg::ResultW-1:0]    result_o,
  output logic                             zero_o
);

  localparam int unsigned LnProdW = fplog_pkg::L2W + 16;
  localparam int unsigned LeW     = fplog_pkg::L2W;
  localparam int unsigned ScProdW = fplog_pkg::ScaleW + LeW;

  logic                               s6_valid_q;
  logic [LnProdW-1:0]                 s6_prod_q;
  logic                               s6_zero_q;
  logic [LnProdW:0]                   ln_round;
  logic [LeW-1:0]                     le;
  logic                               s7_valid_q;
  logic [ScProdW-1:0]                 s7_prod_q;
  logic                               s7_zero_q;
  logic [ScProdW:0]                   sc_round;
  logic [ScProdW-16:0]                sc;
  logic [fplog_pkg::ResultW-1:0]      result_d;
  logic                               s8_valid_q;
  logic [fplog_pkg::ResultW-1:0]      s8_result_q;
  logic                               s8_zero_q;

  // Round the natural log back to Q16.
  assign ln_round = {1'b0, s6_prod_q} + (LnProdW + 1)'(fplog_pkg::HalfQ16);
  assign le       = ln_round[LnProdW-1:16];

  // Round the scaled value and clamp it to the result width.
  always_comb begin
    sc_round = {1'b0, s7_prod_q} + (ScProdW + 1)'(fplog_pkg::HalfQ16);
    sc       = sc_round[ScProdW:16];
    if (s7_zero_q) begin
      result_d = '0;
    end else if (sc > (ScProdW - 15)'({fplog_pkg::ResultW{1'b1}})) begin
      result_d = '1;
    end else begin
      result_d = sc[fplog_pkg::ResultW-1:0];
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
      s7_valid_q <= 1'b0;
      s8_valid_q <= 1'b0;
    end else if (en_i) begin
      s6_valid_q <= valid_i;
      s7_valid_q <= s6_valid_q;
      s8_valid_q <= s7_valid_q;
    end
  end

  // Payload of the three stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s6_prod_q   <= fplog_pkg::Ln2Q16 * l2_i;
      s6_zero_q   <= zero_i;
      s7_prod_q   <= scale_i * le;
      s7_zero_q   <= s6_zero_q;
      s8_result_q <= result_d;
      s8_zero_q   <= s7_zero_q;
    end
  end

  assign valid_o  = s8_valid_q;
  assign result_o = s8_result_q;
  assign zero_o   = s8_zero_q;

endmodule

`default_nettype wire

// File: design/fixed_point_natural_log_core.sv
// Fixed-point natural logarithm core: ln(value) * output_scale, rounded and saturated.
// Eight-stage pipeline: an item is taken every cycle unless a finished result
// is held back; a stalled output freezes all eight stages at once, so
// in_stall_o follows out_stall_i while a result is waiting. A zero operand
// gives result 0 with zero_input_o set. output_scale is written over the APB
// port at byte address 0.
// Depends on fplog_pkg, fplog_lod_norm, fplog_interp and fplog_scale.
`default_nettype none

module fixed_point_natural_log_core (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // Input channel.
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire [fplog_pkg::ValueW-1:0]           value_i,
  // Output channel.
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic [fplog_pkg::ResultW-1:0]         log_result_o,
  output logic                                  zero_input_o,
  // Configuration port.
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire [2:0]                             paddr,
  input  wire [31:0]                            pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  logic                              en;
  logic [fplog_pkg::ScaleW-1:0]      scale_q;
  logic                              cfg_wr;
  logic                              ln_valid;
  logic [fplog_pkg::IpW-1:0]         ln_ip;
  logic [fplog_pkg::FracW-1:0]       ln_frac;
  logic                              ln_zero;
  logic                              ip_valid;
  logic [fplog_pkg::L2W-1:0]         ip_l2;
  logic                              ip_zero;

  // The whole pipeline moves unless a finished result is held back.
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == fplog_pkg::RegOutputScale);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= fplog_pkg::ScaleReset;
    end else if (cfg_wr) begin
      scale_q <= pwdata[fplog_pkg::ScaleW-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == fplog_pkg::RegOutputScale) begin
      prdata = {{(32 - fplog_pkg::ScaleW){1'b0}}, scale_q};
    end else begin
      prdata = '0;
    end
  end

  // Leading one and normalisation.
  fplog_lod_norm u_lod_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .value_i (value_i),
    .valid_o (ln_valid),
    .ip_o    (ln_ip),
    .frac_o  (ln_frac),
    .zero_o  (ln_zero)
  );

  // Table correction and log2 sum.
  fplog_interp u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ln_valid),
    .ip_i    (ln_ip),
    .frac_i  (ln_frac),
    .zero_i  (ln_zero),
    .valid_o (ip_valid),
    .l2_o    (ip_l2),
    .zero_o  (ip_zero)
  );

  // Conversion to natural log and output scaling.
  fplog_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (ip_valid),
    .l2_i     (ip_l2),
    .zero_i   (ip_zero),
    .scale_i  (scale_q),
    .valid_o  (out_valid_o),
    .result_o (log_result_o),
    .zero_o   (zero_input_o)
  );

`ifndef SYNTHESIS
  // A zero operand always leaves with a zero result.
  a_zero_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_input_o |-> log_result_o == '0)
    else $error("zero operand gave a nonzero result");

  // The input is only held off by a waiting result.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // A register write lands in the scale register.
  a_cfg_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> scale_q == $past(pwdata[fplog_pkg::ScaleW-1:0]))
    else $error("output scale write lost");

  // A result held back keeps its value.
  a_hold_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(log_result_o) && $stable(zero_input_o))
    else $error("held result changed");
`endif

endmodule

`default_nettype wire
